// ----- design/i2p_pkg.sv -----
// shared types, codes and helpers of the infix to postfix converter
package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int TOKEN_WIDTH = 16;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CODE_W      = 3;
  localparam int ERR_W       = 3;
  localparam int PRIO_W      = 18;
  localparam int IN_USED_W   = TOKEN_WIDTH + CODE_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = TOKEN_WIDTH + CODE_W + ERR_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [PRIO_W-1:0] PRIO_RESET = PRIO_W'(219345);
  localparam logic [CODE_W-1:0] OPEN_MARK  = 3'd7;

  localparam logic [ERR_W-1:0] ERR_OVERFLOW     = 3'b001;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED_CL = 3'b010;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED_OP = 3'b100;

  typedef enum logic [2:0] {
    KIND_OPERAND  = 3'd0,
    KIND_OPERATOR = 3'd1,
    KIND_OPEN     = 3'd2,
    KIND_CLOSE    = 3'd3,
    KIND_END      = 3'd4
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RK_OPERAND  = 2'd0,
    RK_OPERATOR = 2'd1,
    RK_END      = 2'd2
  } rkind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_OPS,
    ST_CLOSE,
    ST_FLUSH,
    ST_END
  } state_t;

  typedef struct packed {
    rkind_t                  kind;
    logic [TOKEN_WIDTH-1:0]  operand;
    logic [CODE_W-1:0]       op;
    logic [ERR_W-1:0]        err;
    logic                    last;
  } result_t;

  function automatic logic [2:0] prio_of(logic [PRIO_W-1:0] prios, logic [CODE_W-1:0] code);
    logic [2:0] p;
    p = 3'd0;
    case (code)
      OP_ADD: p = prios[2:0];
      OP_SUB: p = prios[5:3];
      OP_MUL: p = prios[8:6];
      OP_DIV: p = prios[11:9];
      OP_MOD: p = prios[14:12];
      OP_POW: p = prios[17:15];
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic result_t make_op(logic [CODE_W-1:0] code, logic last);
    result_t r;
    r.kind    = RK_OPERATOR;
    r.operand = '0;
    r.op      = code;
    r.err     = '0;
    r.last    = last;
    return r;
  endfunction

  function automatic result_t make_operand(logic [TOKEN_WIDTH-1:0] token);
    result_t r;
    r.kind    = RK_OPERAND;
    r.operand = token;
    r.op      = '0;
    r.err     = '0;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic result_t make_end(logic [ERR_W-1:0] err);
    result_t r;
    r.kind    = RK_END;
    r.operand = '0;
    r.op      = '0;
    r.err     = err;
    r.last    = 1'b1;
    return r;
  endfunction

endpackage

// ----- design/infix_to_postfix_converter.sv -----
// shunting-yard infix to postfix converter with operator stack and output register
//
// usage:
//   input items arrive on s_tvalid/s_tready with the token kind in s_tuser and
//   operand token and operator code in s_tdata; postfix items leave on
//   m_tvalid/m_tready with the result kind in m_tuser, the last item caused by
//   one input item marked by m_tlast
//   operator priorities are written through cfg_wr_en/cfg_wr_data while idle
//   an open paren or an ignored item is handled in the idle state, an operand
//   in a state of its own; an operator, a close paren or an end of expression
//   pops stack entries, the end of expression then sends the end marker; the
//   sequencer reads one stack entry per cycle while the output is not stalled
//   one item is worked on at a time; s_tready is high only while idle
//   reset empties the stack, clears the error flags and restores the default
//   priorities (+1 -2 *3 /4 %5 ^6)
//   while the receiver stalls the sequencer holds with the next result in the
//   output register and the one after it in a holding register
module infix_to_postfix_converter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [i2p_pkg::PRIO_W-1:0]       cfg_wr_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [i2p_pkg::IN_DATA_W-1:0]    s_tdata,   // operand_token, operator_code
  input  logic [2:0]                       s_tuser,   // kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [i2p_pkg::OUT_DATA_W-1:0]   m_tdata,   // out_operand, out_operator, error_flags
  output logic [1:0]                       m_tuser,   // result_kind
  output logic                             m_tlast    // last_of_run
);

  localparam int TW = i2p_pkg::TOKEN_WIDTH;
  localparam int CW = i2p_pkg::CODE_W;

  i2p_pkg::state_t                 state, state_next;
  logic [i2p_pkg::CNT_W-1:0]       count, count_next;
  logic [i2p_pkg::ERR_W-1:0]       sticky, sticky_next;
  logic [i2p_pkg::PRIO_W-1:0]      prios, prios_next;
  logic                            pend_v, pend_v_next;
  logic [CW-1:0]                   pend_op, pend_op_next;
  logic                            out_valid, out_valid_next;
  i2p_pkg::result_t                obuf, obuf_next;
  logic [TW-1:0]                   in_token, in_token_next;
  logic [CW-1:0]                   in_code, in_code_next;

  logic [CW-1:0]                   stack [i2p_pkg::STACK_DEPTH];
  logic [i2p_pkg::CNT_W-1:0]       count_m1;
  logic [i2p_pkg::STACK_AW-1:0]    top_idx;
  logic [CW-1:0]                   top;
  logic                            full;
  logic                            go;
  logic                            push_en;
  logic [CW-1:0]                   push_val;
  logic                            pop_top;
  logic                            finish;
  logic                            finish_last;

  assign count_m1 = count - 1'b1;
  assign top_idx  = count_m1[i2p_pkg::STACK_AW-1:0];
  assign top      = stack[top_idx];
  assign full     = (count == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
  assign go       = !out_valid || m_tready;

  assign s_tready = (state == i2p_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = i2p_pkg::OUT_DATA_W'({obuf.err, obuf.op, obuf.operand});
  assign m_tuser  = obuf.kind;
  assign m_tlast  = obuf.last;

  always_comb begin
    state_next     = state;
    count_next     = count;
    sticky_next    = sticky;
    prios_next     = prios;
    pend_v_next    = pend_v;
    pend_op_next   = pend_op;
    out_valid_next = out_valid && !m_tready;
    obuf_next      = obuf;
    in_token_next  = in_token;
    in_code_next   = in_code;
    push_en        = 1'b0;
    push_val       = in_code;
    pop_top        = 1'b0;
    finish         = 1'b0;
    finish_last    = 1'b1;

    if (cfg_wr_en) begin
      prios_next = cfg_wr_data;
    end

    case (state)
      i2p_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          in_token_next = s_tdata[TW-1:0];
          in_code_next  = s_tdata[TW+CW-1:TW];
          case (s_tuser)
            i2p_pkg::KIND_OPERAND:  state_next = i2p_pkg::ST_OPND;
            i2p_pkg::KIND_OPERATOR: begin
              if (s_tdata[TW+CW-1:TW] <= CW'(i2p_pkg::OP_POW)) begin
                state_next = i2p_pkg::ST_OPS;
              end
            end
            i2p_pkg::KIND_OPEN: begin
              push_en  = 1'b1;
              push_val = i2p_pkg::OPEN_MARK;
            end
            i2p_pkg::KIND_CLOSE:    state_next = i2p_pkg::ST_CLOSE;
            i2p_pkg::KIND_END:      state_next = i2p_pkg::ST_FLUSH;
            default: ;
          endcase
        end
      end
      i2p_pkg::ST_OPND: begin
        if (go) begin
          out_valid_next = 1'b1;
          obuf_next      = i2p_pkg::make_operand(in_token);
          state_next     = i2p_pkg::ST_IDLE;
        end
      end
      i2p_pkg::ST_OPS: begin
        if (go) begin
          if (count != '0 && top != i2p_pkg::OPEN_MARK &&
              i2p_pkg::prio_of(prios, in_code) <= i2p_pkg::prio_of(prios, top)) begin
            pop_top = 1'b1;
          end else begin
            finish     = 1'b1;
            push_en    = 1'b1;
            state_next = i2p_pkg::ST_IDLE;
          end
        end
      end
      i2p_pkg::ST_CLOSE: begin
        if (go) begin
          if (count == '0) begin
            sticky_next = sticky | i2p_pkg::ERR_UNMATCHED_CL;
            finish      = 1'b1;
            state_next  = i2p_pkg::ST_IDLE;
          end else if (top == i2p_pkg::OPEN_MARK) begin
            count_next = count_m1;
            finish     = 1'b1;
            state_next = i2p_pkg::ST_IDLE;
          end else begin
            pop_top = 1'b1;
          end
        end
      end
      i2p_pkg::ST_FLUSH: begin
        if (go) begin
          if (count == '0) begin
            finish      = 1'b1;
            finish_last = 1'b0;
            state_next  = i2p_pkg::ST_END;
          end else if (top == i2p_pkg::OPEN_MARK) begin
            sticky_next = sticky | i2p_pkg::ERR_UNMATCHED_OP;
            count_next  = count_m1;
          end else begin
            pop_top = 1'b1;
          end
        end
      end
      i2p_pkg::ST_END: begin
        if (go) begin
          out_valid_next = 1'b1;
          obuf_next      = i2p_pkg::make_end(sticky);
          sticky_next    = '0;
          count_next     = '0;
          state_next     = i2p_pkg::ST_IDLE;
        end
      end
      default: state_next = i2p_pkg::ST_IDLE;
    endcase

    // popped operator waits until it is known whether it is the last one
    if (pop_top) begin
      count_next   = count_m1;
      pend_op_next = top;
      pend_v_next  = 1'b1;
      if (pend_v) begin
        out_valid_next = 1'b1;
        obuf_next      = i2p_pkg::make_op(pend_op, 1'b0);
      end
    end

    if (finish && pend_v) begin
      out_valid_next = 1'b1;
      obuf_next      = i2p_pkg::make_op(pend_op, finish_last);
      pend_v_next    = 1'b0;
    end

    if (push_en) begin
      if (full) begin
        sticky_next = sticky_next | i2p_pkg::ERR_OVERFLOW;
      end else begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= i2p_pkg::ST_IDLE;
      count     <= '0;
      sticky    <= '0;
      prios     <= i2p_pkg::PRIO_RESET;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sticky    <= sticky_next;
      prios     <= prios_next;
      pend_v    <= pend_v_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_op  <= pend_op_next;
    obuf     <= obuf_next;
    in_token <= in_token_next;
    in_code  <= in_code_next;
    if (!rst && push_en && !full) begin
      stack[count[i2p_pkg::STACK_AW-1:0]] <= push_val;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == i2p_pkg::ST_IDLE || state == i2p_pkg::ST_OPND || state == i2p_pkg::ST_END)
      |-> !pend_v)
    else $error("held operator left behind");

  assert property (@(posedge clk) disable iff (rst)
    (state == i2p_pkg::ST_END && go) |=> (count == '0 && sticky == '0))
    else $error("stack or flags not cleared after end marker");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && obuf.kind == i2p_pkg::RK_END) |-> obuf.last)
    else $error("end marker without last flag");

endmodule

// ----- dv/infix_to_postfix_checker.sv -----
// checker of the infix to postfix converter: predicts postfix items and compares them
module infix_to_postfix_checker
  import i2p_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [PRIO_W-1:0]     cfg_wr_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [2:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [1:0]            m_tuser,
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    pending
);

  result_t           expected_q[$];
  logic [CODE_W-1:0] op_stack [STACK_DEPTH];
  int                depth;
  logic [ERR_W-1:0]  sticky;
  logic [PRIO_W-1:0] prio_cfg;
  result_t           got;
  result_t           want;

  function automatic logic [2:0] rank(input logic [CODE_W-1:0] code);
    return prio_cfg[3 * int'(code) +: 3];
  endfunction

  function automatic result_t postfix_item(input rkind_t k, input logic [TOKEN_WIDTH-1:0] opnd,
                                           input logic [CODE_W-1:0] op,
                                           input logic [ERR_W-1:0] err);
    result_t r;
    r.kind    = k;
    r.operand = opnd;
    r.op      = op;
    r.err     = err;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [TOKEN_WIDTH-1:0] g,
                             input logic [TOKEN_WIDTH-1:0] w);
    if (g !== w) report($sformatf("%s got %0h want %0h", name, g, w));
  endtask

  task automatic push_op(input logic [CODE_W-1:0] v);
    if (depth >= STACK_DEPTH) begin
      sticky |= ERR_OVERFLOW;
    end else begin
      op_stack[depth] = v;
      depth++;
    end
  endtask

  task automatic predict(input logic [2:0] kind, input logic [TOKEN_WIDTH-1:0] token,
                         input logic [CODE_W-1:0] code);
    result_t           run[$];
    logic [CODE_W-1:0] top;
    logic              found;
    found = 1'b0;
    case (kind)
      KIND_OPERAND: begin
        run.push_back(postfix_item(RK_OPERAND, token, '0, '0));
      end
      KIND_OPERATOR: begin
        if (code <= OP_POW) begin
          while (depth > 0) begin
            top = op_stack[depth-1];
            if (top == OPEN_MARK || rank(code) > rank(top)) break;
            run.push_back(postfix_item(RK_OPERATOR, '0, top, '0));
            depth--;
          end
          push_op(code);
        end
      end
      KIND_OPEN: begin
        push_op(OPEN_MARK);
      end
      KIND_CLOSE: begin
        while (depth > 0) begin
          top = op_stack[depth-1];
          depth--;
          if (top == OPEN_MARK) begin
            found = 1'b1;
            break;
          end
          run.push_back(postfix_item(RK_OPERATOR, '0, top, '0));
        end
        if (!found) sticky |= ERR_UNMATCHED_CL;
      end
      KIND_END: begin
        while (depth > 0) begin
          top = op_stack[depth-1];
          depth--;
          if (top == OPEN_MARK) sticky |= ERR_UNMATCHED_OP;
          else run.push_back(postfix_item(RK_OPERATOR, '0, top, '0));
        end
        run.push_back(postfix_item(RK_END, '0, '0, sticky));
        sticky = '0;
      end
      default: begin
      end
    endcase
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_q.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      depth    = 0;
      sticky   = '0;
      prio_cfg = PRIO_RESET;
    end else begin
      if (cfg_wr_en) prio_cfg = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        got.kind    = rkind_t'(m_tuser);
        got.operand = m_tdata[TOKEN_WIDTH-1:0];
        got.op      = m_tdata[TOKEN_WIDTH +: CODE_W];
        got.err     = m_tdata[TOKEN_WIDTH+CODE_W +: ERR_W];
        got.last    = m_tlast;
        if (expected_q.size() == 0) begin
          report($sformatf("result of kind %0d with nothing expected", m_tuser));
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", TOKEN_WIDTH'(got.kind), TOKEN_WIDTH'(want.kind));
          check_field("out_operand", got.operand, want.operand);
          check_field("out_operator", TOKEN_WIDTH'(got.op), TOKEN_WIDTH'(want.op));
          check_field("last_of_run", TOKEN_WIDTH'(got.last), TOKEN_WIDTH'(want.last));
          check_field("error_flags", TOKEN_WIDTH'(got.err), TOKEN_WIDTH'(want.err));
        end
      end
      if (s_tvalid && s_tready) begin
        predict(s_tuser, s_tdata[TOKEN_WIDTH-1:0], s_tdata[TOKEN_WIDTH +: CODE_W]);
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ----- dv/infix_to_postfix_converter_tb.sv -----
// testbench top of the infix to postfix converter: stimulus, idling and verdict
module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_IDLE       = 16;
  localparam logic [2:0] CODE_MAX = 3'd7;
  localparam logic [2:0] KIND_MAX = 3'd7;
  localparam logic [PRIO_W-1:0] PRIO_ALL_MAX  = '1;
  localparam logic [PRIO_W-1:0] PRIO_ALL_MIN  = '0;
  localparam logic [PRIO_W-1:0] PRIO_REVERSED = {3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

  typedef struct {
    logic [2:0]             kind;
    logic [TOKEN_WIDTH-1:0] token;
    logic [CODE_W-1:0]      code;
  } token_item_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [PRIO_W-1:0]     cfg_wr_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [2:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  int          next_gap;
  bit          valid_held;
  bit          no_idle;
  token_item_t expr_q[$];

  infix_to_postfix_converter u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  infix_to_postfix_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_cycles();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [TOKEN_WIDTH-1:0] rnd_token();
    return TOKEN_WIDTH'($urandom);
  endfunction

  function automatic logic [CODE_W-1:0] rnd_code();
    return CODE_W'($urandom);
  endfunction

  function automatic logic [CODE_W-1:0] rnd_op();
    return CODE_W'($urandom_range(OP_ADD, OP_POW));
  endfunction

  function automatic logic [2:0] rnd_kind();
    return 3'($urandom);
  endfunction

  task automatic add_item(input logic [2:0] kind, input logic [TOKEN_WIDTH-1:0] token,
                          input logic [CODE_W-1:0] code);
    token_item_t it;
    it.kind  = kind;
    it.token = token;
    it.code  = code;
    expr_q.push_back(it);
  endtask

  task automatic send_expr(inout int counted);
    token_item_t it;
    while (expr_q.size() > 0) begin
      it = expr_q.pop_front();
      repeat (next_gap) @(posedge clk);
      s_tvalid <= 1'b1;
      s_tdata  <= IN_DATA_W'({it.code, it.token});
      s_tuser  <= it.kind;
      do @(posedge clk); while (!s_tready);
      next_gap   = idle_cycles();
      valid_held = (next_gap == 0);
      if (!valid_held) s_tvalid <= 1'b0;
      if (it.kind <= KIND_END && (it.kind != KIND_OPERATOR || it.code <= OP_POW)) counted++;
    end
  endtask

  task automatic wait_drained();
    if (valid_held) s_tvalid <= 1'b0;
    valid_held = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_priorities(input logic [PRIO_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic build_wellformed(input int nterms);
    int opened;
    opened = 0;
    for (int i = 0; i < nterms; i++) begin
      if (i > 0) add_item(KIND_OPERATOR, rnd_token(), rnd_op());
      while (opened < 20 && $urandom_range(0, 3) == 0) begin
        add_item(KIND_OPEN, rnd_token(), rnd_code());
        opened++;
      end
      add_item(KIND_OPERAND, rnd_token(), rnd_code());
      while (opened > 0 && $urandom_range(0, 2) == 0) begin
        add_item(KIND_CLOSE, rnd_token(), rnd_code());
        opened--;
      end
    end
    repeat (opened) add_item(KIND_CLOSE, rnd_token(), rnd_code());
    add_item(KIND_END, rnd_token(), rnd_code());
  endtask

  task automatic random_phase(input int target);
    int          counted;
    int          pick;
    int          n;
    int          idx;
    token_item_t noise;
    counted = 0;
    while (counted < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 9);
      n       = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      if (pick <= 6) begin
        build_wellformed(n);
      end else if (pick == 7) begin
        // well-formed expression with one item broken or dropped
        build_wellformed(n);
        idx         = $urandom_range(0, expr_q.size() - 1);
        noise.kind  = rnd_kind();
        noise.token = rnd_token();
        noise.code  = rnd_code();
        if ($urandom_range(0, 1) == 0) expr_q.delete(idx);
        else expr_q[idx] = noise;
      end else if (pick == 8) begin
        // deep nesting to run the stack full
        n = $urandom_range(12, 20);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) begin
            add_item(KIND_OPERAND, rnd_token(), rnd_code());
            add_item(KIND_OPERATOR, rnd_token(), rnd_op());
          end
          add_item(KIND_OPEN, rnd_token(), rnd_code());
        end
        add_item(KIND_OPERAND, rnd_token(), rnd_code());
        repeat (n) add_item(KIND_CLOSE, rnd_token(), rnd_code());
        add_item(KIND_END, rnd_token(), rnd_code());
      end else begin
        repeat ($urandom_range(1, 6)) add_item(rnd_kind(), rnd_token(), rnd_code());
        if ($urandom_range(0, 1) == 0) add_item(KIND_END, rnd_token(), rnd_code());
      end
      send_expr(counted);
    end
  endtask

  initial begin
    int                counted;
    logic [PRIO_W-1:0] prio_plan [5];
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= '0;
    next_gap    = 0;
    valid_held  = 1'b0;
    no_idle     = 1'b0;
    counted     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // every operator in one chain, token extremes
    add_item(KIND_OPERAND, '0, OP_ADD);
    add_item(KIND_OPERATOR, '1, OP_ADD);
    add_item(KIND_OPERAND, '1, CODE_MAX);
    for (int c = OP_SUB; c <= OP_POW; c++) begin
      add_item(KIND_OPERATOR, '0, CODE_W'(c));
      add_item(KIND_OPERAND, rnd_token(), '0);
    end
    add_item(KIND_END, '0, '0);
    // unmatched close
    add_item(KIND_CLOSE, '0, '0);
    add_item(KIND_END, '0, '0);
    // unmatched open left at the end
    add_item(KIND_OPEN, '0, '0);
    add_item(KIND_OPERAND, 16'h5a5a, '0);
    add_item(KIND_OPERATOR, '0, OP_MUL);
    add_item(KIND_OPERAND, 16'ha5a5, '0);
    add_item(KIND_END, '0, '0);
    // ignored items and an empty expression
    add_item(KIND_OPERATOR, '0, CODE_W'(OP_POW + 1));
    add_item(KIND_OPERATOR, '1, CODE_MAX);
    add_item(3'(KIND_END + 1), '1, OP_ADD);
    add_item(KIND_MAX, '1, CODE_MAX);
    add_item(KIND_END, '1, CODE_MAX);
    send_expr(counted);

    random_phase(60);
    prio_plan = '{PRIO_ALL_MAX, PRIO_ALL_MIN, PRIO_W'($urandom), PRIO_REVERSED, PRIO_RESET};
    foreach (prio_plan[i]) begin
      set_priorities(prio_plan[i]);
      random_phase(65);
    end

    wait_drained();
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int stall;
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        stall = idle_cycles();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
